// ----- hdl/hrmr_pkg.sv -----
`timescale 1ns / 1ps
package hrmr_pkg;

	localparam int SLOT_COUNT    = 4;
	localparam int PAYLOAD_BYTES = 256;
	localparam int REPORT_BYTES  = 64;
	localparam int MIN_REPORT    = 5;
	localparam int HEADER_FIXED  = 4;
	localparam logic [7:0] EXT_LEN_MARK = 8'h00;

	localparam int SLOT_W = 2;
	localparam int POS_W  = 9;
	localparam int RPOS_W = 7;
	localparam int ADDR_W = 10;

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_READ    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		SS_EMPTY   = 2'd0,
		SS_PENDING = 2'd1,
		SS_READY   = 2'd2
	} slot_state_t;

	typedef enum logic [2:0] {
		K_BAD    = 3'd0,
		K_SINGLE = 3'd1,
		K_FIRST  = 3'd2,
		K_MIDDLE = 3'd3,
		K_LAST   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK       = 4'd0,
		ST_FRAGMENT = 4'd1,
		ST_BAD_SUM  = 4'd2,
		ST_BAD_LINK = 4'd3,
		ST_SHORT    = 4'd4,
		ST_NO_SLOT  = 4'd5,
		ST_TOO_BIG  = 4'd6,
		ST_READ     = 4'd7,
		ST_RELEASED = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		CFG_SINGLE = 3'd0,
		CFG_LAST   = 3'd1,
		CFG_FIRST  = 3'd2,
		CFG_MIDDLE = 3'd3,
		CFG_WIDE   = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] code_single;
		logic [7:0] code_last;
		logic [7:0] code_first;
		logic [7:0] code_middle;
		logic [7:0] wide_lingo;
	} cfg_t;

	// payload store request from the control path
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [1:0]  slot_used;
		logic [7:0]  lingo;
		logic [15:0] command;
		logic [15:0] transaction;
		logic [8:0]  payload_length;
		logic        read_zero;
	} result_t;

endpackage

// ----- hdl/hrmr_payload_ram.sv -----
`timescale 1ns / 1ps
module hrmr_payload_ram (
	input  logic                       clk,
	input  hrmr_pkg::mem_req_t         req,
	output logic [7:0]                 rd_data
);

	logic [7:0] mem [2**hrmr_pkg::ADDR_W];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_data <= mem[req.rd_addr];
	end

endmodule

// ----- hdl/hid_report_message_reassembler_core.sv -----
`timescale 1ns / 1ps
// HID report message reassembler.
// s_axis carries one request per beat: report bytes (opcode 0, tlast marks
// the final byte of a report), payload reads (opcode 1) and slot releases
// (opcode 2). A report byte updates the running header/sum/position state once
// it reaches the request register; the report's final byte, a read or a release
// produces one result on m_axis, other report bytes produce none.
// A result passes through the request register, the result register (joined by
// the payload memory read) and the output queue before it is valid on m_axis.
// Throughput: one request per cycle while s_axis_tready is high; the cfg
// channel is always ready and must only be written while idle.
// A stalled m_axis receiver is absorbed by a four-entry queue after the
// result register; s_axis_tready drops only when that queue cannot take the
// requests already in flight.
// Reset clears all slot status and tables, position and config registers to
// their defaults. Payload bytes are only read below the stored count, so the
// payload memory needs no clearing pass after reset.
module hid_report_message_reassembler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // opcode[1:0], data_byte[9:2], slot[11:10], index[19:12]
	input  logic        s_axis_tlast,  // last_of_report
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // status, slot_used, lingo, command, transaction,
	                                   // payload_length, read_data
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int NS = hrmr_pkg::SLOT_COUNT;
	localparam int AW = hrmr_pkg::ADDR_W;
	localparam int PW = hrmr_pkg::POS_W;

	hrmr_pkg::cfg_t cfg_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4};
		end else if (cfg_valid) begin
			case (hrmr_pkg::cfg_index_t'(cfg_index))
				hrmr_pkg::CFG_SINGLE: cfg_q.code_single <= cfg_data;
				hrmr_pkg::CFG_LAST:   cfg_q.code_last   <= cfg_data;
				hrmr_pkg::CFG_FIRST:  cfg_q.code_first  <= cfg_data;
				hrmr_pkg::CFG_MIDDLE: cfg_q.code_middle <= cfg_data;
				hrmr_pkg::CFG_WIDE:   cfg_q.wide_lingo  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic        v_s1;
	logic [1:0]  op_s1;
	logic [7:0]  b_s1;
	logic        last_s1;
	logic [1:0]  sl_s1;
	logic [7:0]  idx_s1;
	logic        acc;

	assign acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1   <= s_axis_tdata[1:0];
			b_s1    <= s_axis_tdata[9:2];
			sl_s1   <= s_axis_tdata[11:10];
			idx_s1  <= s_axis_tdata[19:12];
			last_s1 <= s_axis_tlast;
		end
	end

	// state
	logic [1:0]  st_q   [NS];
	logic [7:0]  lg_q   [NS];
	logic [15:0] cmd_q  [NS];
	logic [15:0] tr_q   [NS];
	logic [PW-1:0] rem_q [NS];
	logic [PW-1:0] wp_q  [NS];
	logic [7:0]  sum_q  [NS];

	logic [6:0]  rpos_q;
	logic [39:0] hdr_q;
	logic [2:0]  kind_q;
	logic        act_v_q;
	logic [1:0]  act_q;
	logic        lext_q, wide_q, hdone_q, ck_seen_q;
	logic [15:0] mlen_q;
	logic [PW-1:0] base_q, wr_q, rrem_q;
	logic [7:0]  rsum_q, ck_q;
	logic [3:0]  fault_q;

	// next-value copies
	logic [1:0]  st_n   [NS];
	logic [7:0]  lg_n   [NS];
	logic [15:0] cmd_n  [NS];
	logic [15:0] tr_n   [NS];
	logic [PW-1:0] rem_n [NS];
	logic [PW-1:0] wp_n  [NS];
	logic [7:0]  sum_n  [NS];
	logic [6:0]  rpos_n;
	logic [39:0] hdr_n;
	logic [2:0]  kind_n;
	logic        act_v_n;
	logic [1:0]  act_n;
	logic        lext_n, wide_n, hdone_n, ck_seen_n;
	logic [15:0] mlen_n;
	logic [PW-1:0] base_n, wr_n, rrem_n;
	logic [7:0]  rsum_n, ck_n;
	logic [3:0]  fault_n;

	hrmr_pkg::mem_req_t  mreq;
	hrmr_pkg::result_t   res;
	logic                res_v;

	logic [6:0]  p;
	logic [3:0]  hp, cend;
	logic [15:0] need;
	logic [15:0] cmdv;
	logic [PW-1:0] pos;
	logic [3:0]  stv;
	logic        ends;
	logic [1:0]  s;

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			st_n[i] = st_q[i]; lg_n[i] = lg_q[i]; cmd_n[i] = cmd_q[i];
			tr_n[i] = tr_q[i]; rem_n[i] = rem_q[i]; wp_n[i] = wp_q[i];
			sum_n[i] = sum_q[i];
		end
		rpos_n = rpos_q; hdr_n = hdr_q; kind_n = kind_q; act_v_n = act_v_q;
		act_n = act_q; lext_n = lext_q; wide_n = wide_q; hdone_n = hdone_q;
		ck_seen_n = ck_seen_q; mlen_n = mlen_q; base_n = base_q; wr_n = wr_q;
		rrem_n = rrem_q; rsum_n = rsum_q; ck_n = ck_q; fault_n = fault_q;
		mreq = '0;
		mreq.rd_addr = {sl_s1, idx_s1};
		res = '0;
		res_v = 1'b0;
		p = rpos_q;
		hp = 4'd0; cend = 4'd0; need = 16'd0; cmdv = 16'd0; pos = '0;
		stv = hrmr_pkg::ST_OK; ends = 1'b0; s = act_q;

		if (v_s1 && op_s1 == hrmr_pkg::OP_BYTE) begin
			if (32'(p) < hrmr_pkg::REPORT_BYTES) begin
				rpos_n = p + 7'd1;
				if (p == 7'd0) begin
					kind_n = hrmr_pkg::K_BAD; lext_n = 1'b0; wide_n = 1'b0;
					hdone_n = 1'b0; ck_seen_n = 1'b0; mlen_n = '0; base_n = '0;
					wr_n = '0; rrem_n = '0; rsum_n = '0; ck_n = '0;
					fault_n = hrmr_pkg::ST_OK;
					hdr_n = '0; act_v_n = 1'b0; act_n = '0;
				end else if (p == 7'd1) begin
					if (b_s1 == cfg_q.code_single) kind_n = hrmr_pkg::K_SINGLE;
					else if (b_s1 == cfg_q.code_last) kind_n = hrmr_pkg::K_LAST;
					else if (b_s1 == cfg_q.code_first) kind_n = hrmr_pkg::K_FIRST;
					else if (b_s1 == cfg_q.code_middle) kind_n = hrmr_pkg::K_MIDDLE;
					else kind_n = hrmr_pkg::K_BAD;
					if (kind_n != hrmr_pkg::K_BAD) begin
						for (int i = NS - 1; i >= 0; i--) begin
							if (st_q[i] == hrmr_pkg::SS_PENDING ||
								((kind_n == hrmr_pkg::K_SINGLE ||
								  kind_n == hrmr_pkg::K_FIRST) &&
								 st_q[i] == hrmr_pkg::SS_EMPTY)) begin
								act_v_n = 1'b1;
								act_n = 2'(i);
							end
						end
						if (act_v_n && (kind_n == hrmr_pkg::K_MIDDLE ||
							kind_n == hrmr_pkg::K_LAST)) begin
							hdone_n = 1'b1;
							base_n = wp_q[act_n];
							rrem_n = rem_q[act_n];
							rsum_n = sum_q[act_n];
						end
					end
				end else if (kind_q != hrmr_pkg::K_BAD && act_v_q) begin
					if (!hdone_q) begin
						if (p != 7'd2) begin
							rsum_n = rsum_q + b_s1;
							hp = lext_q ? 4'd6 : 4'd4;
							cend = hp + (wide_q ? 4'd3 : 4'd2);
							if (p == 7'd3) begin
								if (b_s1 == hrmr_pkg::EXT_LEN_MARK) lext_n = 1'b1;
								else mlen_n = {8'd0, b_s1};
							end else if (lext_q && p == 7'd4) begin
								mlen_n = {b_s1, 8'd0};
							end else if (lext_q && p == 7'd5) begin
								mlen_n = {mlen_q[15:8], b_s1};
							end else if (p == 7'(hp)) begin
								wide_n = (b_s1 == cfg_q.wide_lingo);
								hdr_n = {b_s1, 32'd0};
							end else if (p < 7'(cend)) begin
								cmdv = {hdr_q[23:16], b_s1};
								hdr_n = {hdr_q[39:32], cmdv, hdr_q[15:0]};
							end else if (p == 7'(cend)) begin
								hdr_n = {hdr_q[39:16], b_s1, 8'd0};
							end else begin
								hdr_n = {hdr_q[39:8], b_s1};
								hdone_n = 1'b1;
								need = 16'(hrmr_pkg::HEADER_FIXED) +
									(wide_q ? 16'd1 : 16'd0);
								if (mlen_q < need) fault_n = hrmr_pkg::ST_SHORT;
								else if (mlen_q - need > 16'(hrmr_pkg::PAYLOAD_BYTES))
									fault_n = hrmr_pkg::ST_TOO_BIG;
								else rrem_n = PW'(mlen_q - need);
							end
						end
					end else if (fault_q == hrmr_pkg::ST_OK) begin
						if (rrem_q != '0) begin
							pos = base_q + wr_q;
							if (32'(pos) < hrmr_pkg::PAYLOAD_BYTES) begin
								mreq.wr_en = 1'b1;
								mreq.wr_addr = AW'({act_q, pos[7:0]});
								mreq.wr_data = b_s1;
							end
							wr_n = wr_q + 1'b1;
							rrem_n = rrem_q - 1'b1;
							rsum_n = rsum_q + b_s1;
						end else if ((kind_q == hrmr_pkg::K_SINGLE ||
							kind_q == hrmr_pkg::K_LAST) && !ck_seen_q) begin
							ck_seen_n = 1'b1;
							ck_n = b_s1;
						end
					end
				end
			end
			if (last_s1) begin
				// finish on the post-byte state
				res_v = 1'b1;
				s = act_n;
				ends = (kind_n == hrmr_pkg::K_SINGLE || kind_n == hrmr_pkg::K_LAST);
				if (32'(rpos_n) < hrmr_pkg::MIN_REPORT) stv = hrmr_pkg::ST_SHORT;
				else if (kind_n == hrmr_pkg::K_BAD) stv = hrmr_pkg::ST_BAD_LINK;
				else if (!act_v_n) stv = hrmr_pkg::ST_NO_SLOT;
				else if ((kind_n == hrmr_pkg::K_SINGLE || kind_n == hrmr_pkg::K_FIRST)
					&& (!hdone_n || fault_n == hrmr_pkg::ST_SHORT))
					stv = hrmr_pkg::ST_SHORT;
				else if ((kind_n == hrmr_pkg::K_SINGLE || kind_n == hrmr_pkg::K_FIRST)
					&& fault_n == hrmr_pkg::ST_TOO_BIG) stv = hrmr_pkg::ST_TOO_BIG;
				else if ((kind_n == hrmr_pkg::K_MIDDLE || kind_n == hrmr_pkg::K_LAST)
					&& st_q[s] != hrmr_pkg::SS_PENDING) stv = hrmr_pkg::ST_NO_SLOT;
				else if (ends && !ck_seen_n) begin
					stv = hrmr_pkg::ST_SHORT;
					st_n[s] = hrmr_pkg::SS_EMPTY; wp_n[s] = '0;
				end else if (ends && (8'd0 - rsum_n) != ck_n) begin
					stv = hrmr_pkg::ST_BAD_SUM;
					st_n[s] = hrmr_pkg::SS_EMPTY; wp_n[s] = '0;
				end else begin
					stv = ends ? hrmr_pkg::ST_OK : hrmr_pkg::ST_FRAGMENT;
					if (kind_n == hrmr_pkg::K_SINGLE || kind_n == hrmr_pkg::K_FIRST) begin
						lg_n[s] = hdr_n[39:32]; cmd_n[s] = hdr_n[31:16];
						tr_n[s] = hdr_n[15:0];
					end
					wp_n[s] = base_n + wr_n;
					rem_n[s] = rrem_n;
					sum_n[s] = rsum_n;
					st_n[s] = ends ? hrmr_pkg::SS_READY : hrmr_pkg::SS_PENDING;
				end
				res.status = stv;
				res.slot_used = act_v_n ? s : 2'd0;
				res.read_zero = 1'b1;
				if (stv == hrmr_pkg::ST_OK || stv == hrmr_pkg::ST_FRAGMENT) begin
					res.lingo = lg_n[s]; res.command = cmd_n[s];
					res.transaction = tr_n[s]; res.payload_length = wp_n[s];
				end
				rpos_n = '0;
			end
		end else if (v_s1 && op_s1 == hrmr_pkg::OP_READ) begin
			res_v = 1'b1;
			res.status = hrmr_pkg::ST_READ;
			res.slot_used = sl_s1;
			res.lingo = lg_q[sl_s1]; res.command = cmd_q[sl_s1];
			res.transaction = tr_q[sl_s1]; res.payload_length = wp_q[sl_s1];
			res.read_zero = !(PW'(idx_s1) < wp_q[sl_s1]);
		end else if (v_s1 && op_s1 == hrmr_pkg::OP_RELEASE) begin
			res_v = 1'b1;
			res.status = hrmr_pkg::ST_RELEASED;
			res.slot_used = sl_s1;
			res.read_zero = 1'b1;
			st_n[sl_s1] = hrmr_pkg::SS_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				st_q[i] <= hrmr_pkg::SS_EMPTY; lg_q[i] <= '0; cmd_q[i] <= '0;
				tr_q[i] <= '0; rem_q[i] <= '0; wp_q[i] <= '0; sum_q[i] <= '0;
			end
			rpos_q <= '0; hdr_q <= '0; kind_q <= hrmr_pkg::K_BAD; act_v_q <= 1'b0;
			act_q <= '0; lext_q <= 1'b0; wide_q <= 1'b0; hdone_q <= 1'b0;
			ck_seen_q <= 1'b0; mlen_q <= '0; base_q <= '0; wr_q <= '0;
			rrem_q <= '0; rsum_q <= '0; ck_q <= '0; fault_q <= hrmr_pkg::ST_OK;
		end else begin
			for (int i = 0; i < NS; i++) begin
				st_q[i] <= st_n[i]; lg_q[i] <= lg_n[i]; cmd_q[i] <= cmd_n[i];
				tr_q[i] <= tr_n[i]; rem_q[i] <= rem_n[i]; wp_q[i] <= wp_n[i];
				sum_q[i] <= sum_n[i];
			end
			rpos_q <= rpos_n; hdr_q <= hdr_n; kind_q <= kind_n; act_v_q <= act_v_n;
			act_q <= act_n; lext_q <= lext_n; wide_q <= wide_n; hdone_q <= hdone_n;
			ck_seen_q <= ck_seen_n; mlen_q <= mlen_n; base_q <= base_n; wr_q <= wr_n;
			rrem_q <= rrem_n; rsum_q <= rsum_n; ck_q <= ck_n; fault_q <= fault_n;
		end
	end

	logic [7:0] rd_data;

	hrmr_payload_ram u_ram (
		.clk     (clk),
		.req     (mreq),
		.rd_data (rd_data)
	);

	// result register; the read byte from the memory joins it in the same cycle
	logic              v_s2;
	hrmr_pkg::result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (res_v) begin
			res_s2 <= res;
		end
	end

	logic [63:0] out_word;
	assign out_word = {1'b0, (res_s2.read_zero ? 8'd0 : rd_data), res_s2.payload_length,
		res_s2.transaction, res_s2.command, res_s2.lingo, res_s2.slot_used,
		res_s2.status};

	// four-entry output queue; ready needs room for every result in flight
	logic [63:0] q_data_q [4];
	logic [2:0]  cnt_q;
	logic [1:0]  rd_ptr_q, wr_ptr_q;
	logic        pop;
	logic [2:0]  inflight;

	assign pop = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = cnt_q != 3'd0;
	assign m_axis_tdata = q_data_q[rd_ptr_q];
	assign inflight = {2'b0, v_s1} + {2'b0, v_s2};
	assign s_axis_tready = (cnt_q + inflight) < 3'd4 || pop && (cnt_q + inflight) == 3'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_ptr_q <= '0; wr_ptr_q <= '0;
		end else begin
			if (v_s2) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, v_s2} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			q_data_q[wr_ptr_q] <= out_word;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !pop |-> cnt_q < 3'd4)
		else $error("output queue overflow");
	a_rpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rpos_q) <= hrmr_pkg::REPORT_BYTES)
		else $error("report position out of range");
	a_wr_only_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.wr_en |-> v_s1 && op_s1 == hrmr_pkg::OP_BYTE && act_v_q)
		else $error("payload write without active slot");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && op_s1 == hrmr_pkg::OP_READ |=> v_s2)
		else $error("read lost its result");
`endif

endmodule

// ----- verif/hid_report_message_reassembler_core_tb.sv -----
`timescale 1ns / 1ps
module hid_report_message_reassembler_core_tb;

	typedef struct {
		hrmr_pkg::opcode_t op;
		logic [7:0] data;
		logic       last;
		logic [1:0] slot;
		logic [7:0] index;
	} request_t;

	typedef struct {
		logic [3:0]  status;
		logic [1:0]  slot_used;
		logic [7:0]  lingo;
		logic [15:0] command;
		logic [15:0] transaction;
		logic [8:0]  payload_length;
		logic [7:0]  read_data;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	hid_report_message_reassembler_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	request_t pending_requests[$];
	outcome_t awaited_results[$];
	request_t cur;
	int       send_gap = 0;
	int       recv_stall = 0;
	bit       calm = 1'b0;
	bit       hold_sender = 1'b0;
	int       errors = 0;
	int       idle_cycles = 0;
	int       n_items = 0;

	// configuration as the predictor sees it (indexed by cfg_index_t)
	logic [7:0] codes [5];

	// predictor state
	hrmr_pkg::slot_state_t sl_state [hrmr_pkg::SLOT_COUNT];
	logic [7:0]  sl_lingo [hrmr_pkg::SLOT_COUNT];
	logic [15:0] sl_cmd   [hrmr_pkg::SLOT_COUNT];
	logic [15:0] sl_trans [hrmr_pkg::SLOT_COUNT];
	int          sl_rem   [hrmr_pkg::SLOT_COUNT];
	int          sl_wpos  [hrmr_pkg::SLOT_COUNT];
	logic [7:0]  sl_sum   [hrmr_pkg::SLOT_COUNT];
	logic [7:0]  store [hrmr_pkg::SLOT_COUNT*hrmr_pkg::PAYLOAD_BYTES];
	int          rpos;
	logic [39:0] hcap;
	int          act;
	bit          act_v;
	hrmr_pkg::kind_t   kind;
	bit          len_ext, wide, hdr_done, ck_seen;
	int          msg_len, base, written, rem;
	logic [7:0]  rsum, ck_byte;
	hrmr_pkg::status_t fault;
	bit          has_fault;

	function automatic void clear_report();
		kind = hrmr_pkg::K_BAD;
		len_ext = 0; wide = 0; hdr_done = 0; ck_seen = 0;
		msg_len = 0; base = 0; written = 0; rem = 0;
		rsum = 0; ck_byte = 0; has_fault = 0; fault = hrmr_pkg::ST_OK;
		hcap = '0; act_v = 0; act = 0;
	endfunction

	function automatic void pick_slot(bit allow_empty);
		for (int s = 0; s < hrmr_pkg::SLOT_COUNT; s++) begin
			if (sl_state[s] == hrmr_pkg::SS_PENDING ||
				(allow_empty && sl_state[s] == hrmr_pkg::SS_EMPTY)) begin
				act = s; act_v = 1;
				return;
			end
		end
	endfunction

	function automatic void classify(logic [7:0] b);
		if (b == codes[hrmr_pkg::CFG_SINGLE]) kind = hrmr_pkg::K_SINGLE;
		else if (b == codes[hrmr_pkg::CFG_LAST]) kind = hrmr_pkg::K_LAST;
		else if (b == codes[hrmr_pkg::CFG_FIRST]) kind = hrmr_pkg::K_FIRST;
		else if (b == codes[hrmr_pkg::CFG_MIDDLE]) kind = hrmr_pkg::K_MIDDLE;
		else begin
			kind = hrmr_pkg::K_BAD;
			return;
		end
		if (kind == hrmr_pkg::K_SINGLE || kind == hrmr_pkg::K_FIRST) begin
			pick_slot(1);
		end else begin
			pick_slot(0);
			if (act_v) begin
				hdr_done = 1;
				base = sl_wpos[act];
				rem = sl_rem[act];
				rsum = sl_sum[act];
			end
		end
	endfunction

	function automatic void header_byte(int p, logic [7:0] b);
		int hp, cend, need;
		if (p == 2) return;
		rsum = rsum + b;
		if (p == 3) begin
			if (b == hrmr_pkg::EXT_LEN_MARK) len_ext = 1; else msg_len = b;
			return;
		end
		if (len_ext && p == 4) begin msg_len = b << 8; return; end
		if (len_ext && p == 5) begin msg_len = msg_len | b; return; end
		hp = len_ext ? 6 : 4;
		if (p == hp) begin
			wide = (b == codes[hrmr_pkg::CFG_WIDE]);
			hcap = {b, 32'h0};
			return;
		end
		cend = hp + (wide ? 2 : 1) + 1;
		if (p < cend) begin
			hcap[31:16] = {hcap[23:16], b};
			return;
		end
		if (p == cend) begin
			hcap[15:0] = {b, 8'h00};
			return;
		end
		hcap[7:0] = b;
		hdr_done = 1;
		need = hrmr_pkg::HEADER_FIXED + (wide ? 1 : 0);
		if (msg_len < need) begin
			has_fault = 1; fault = hrmr_pkg::ST_SHORT;
		end else if (msg_len - need > hrmr_pkg::PAYLOAD_BYTES) begin
			has_fault = 1; fault = hrmr_pkg::ST_TOO_BIG;
		end else rem = msg_len - need;
	endfunction

	function automatic void take_byte(int p, logic [7:0] b);
		if (p == 0) begin clear_report(); return; end
		if (p == 1) begin classify(b); return; end
		if (kind == hrmr_pkg::K_BAD || !act_v) return;
		if (!hdr_done) begin header_byte(p, b); return; end
		if (has_fault) return;
		if (rem > 0) begin
			if (base + written < hrmr_pkg::PAYLOAD_BYTES)
				store[act*hrmr_pkg::PAYLOAD_BYTES + base + written] = b;
			written++;
			rem--;
			rsum = rsum + b;
		end else if ((kind == hrmr_pkg::K_SINGLE || kind == hrmr_pkg::K_LAST) && !ck_seen) begin
			ck_seen = 1;
			ck_byte = b;
		end
	endfunction

	function automatic void commit_slot(int s, hrmr_pkg::slot_state_t st);
		if (kind == hrmr_pkg::K_SINGLE || kind == hrmr_pkg::K_FIRST) begin
			sl_lingo[s] = hcap[39:32];
			sl_cmd[s] = hcap[31:16];
			sl_trans[s] = hcap[15:0];
		end
		sl_wpos[s] = base + written;
		sl_rem[s] = rem;
		sl_sum[s] = rsum;
		sl_state[s] = st;
	endfunction

	function automatic hrmr_pkg::status_t finish_report();
		bit ends;
		ends = (kind == hrmr_pkg::K_SINGLE || kind == hrmr_pkg::K_LAST);
		if (rpos < hrmr_pkg::MIN_REPORT) return hrmr_pkg::ST_SHORT;
		if (kind == hrmr_pkg::K_BAD) return hrmr_pkg::ST_BAD_LINK;
		if (!act_v) return hrmr_pkg::ST_NO_SLOT;
		if (kind == hrmr_pkg::K_SINGLE || kind == hrmr_pkg::K_FIRST) begin
			if (!hdr_done || (has_fault && fault == hrmr_pkg::ST_SHORT))
				return hrmr_pkg::ST_SHORT;
			if (has_fault) return hrmr_pkg::ST_TOO_BIG;
		end else if (sl_state[act] != hrmr_pkg::SS_PENDING) begin
			return hrmr_pkg::ST_NO_SLOT;
		end
		if (!ends) begin
			commit_slot(act, hrmr_pkg::SS_PENDING);
			return hrmr_pkg::ST_FRAGMENT;
		end
		if (!ck_seen || (8'(-rsum) != ck_byte)) begin
			sl_state[act] = hrmr_pkg::SS_EMPTY;
			sl_wpos[act] = 0;
			return ck_seen ? hrmr_pkg::ST_BAD_SUM : hrmr_pkg::ST_SHORT;
		end
		commit_slot(act, hrmr_pkg::SS_READY);
		return hrmr_pkg::ST_OK;
	endfunction

	// advance the predictor by one accepted request
	function automatic void reassemble_step(request_t r);
		outcome_t o;
		hrmr_pkg::status_t st;
		if (r.op == hrmr_pkg::OP_NONE) return;
		if (r.op == hrmr_pkg::OP_BYTE) begin
			if (rpos < hrmr_pkg::REPORT_BYTES) begin
				take_byte(rpos, r.data);
				rpos++;
			end
			if (!r.last) return;
		end
		o = '{default: '0};
		if (r.op == hrmr_pkg::OP_READ) begin
			o.status = hrmr_pkg::ST_READ;
			o.slot_used = r.slot;
			o.lingo = sl_lingo[r.slot];
			o.command = sl_cmd[r.slot];
			o.transaction = sl_trans[r.slot];
			o.payload_length = 9'(sl_wpos[r.slot]);
			if (r.index < sl_wpos[r.slot])
				o.read_data = store[r.slot*hrmr_pkg::PAYLOAD_BYTES + r.index];
		end else if (r.op == hrmr_pkg::OP_RELEASE) begin
			sl_state[r.slot] = hrmr_pkg::SS_EMPTY;
			o.status = hrmr_pkg::ST_RELEASED;
			o.slot_used = r.slot;
		end else begin
			st = finish_report();
			o.status = st;
			o.slot_used = act_v ? 2'(act) : 2'd0;
			if (st == hrmr_pkg::ST_OK || st == hrmr_pkg::ST_FRAGMENT) begin
				o.lingo = sl_lingo[act];
				o.command = sl_cmd[act];
				o.transaction = sl_trans[act];
				o.payload_length = 9'(sl_wpos[act]);
			end
			rpos = 0;
		end
		awaited_results.push_back(o);
	endfunction

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				reassemble_step(cur);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0 && !hold_sender) begin
					cur = pending_requests.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'b0, cur.index, cur.slot, cur.data, cur.op};
					s_axis_tlast <= cur.last;
					send_gap <= draw_wait();
					if ($urandom_range(0, 63) == 0) calm <= ~calm;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// receiver
	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %0h",
						$time, m_axis_tdata);
					errors++;
				end else begin
					e = awaited_results.pop_front();
					check_field("status", e.status, m_axis_tdata[3:0]);
					check_field("slot_used", e.slot_used, m_axis_tdata[5:4]);
					check_field("lingo", e.lingo, m_axis_tdata[13:6]);
					check_field("command", e.command, m_axis_tdata[29:14]);
					check_field("transaction", e.transaction, m_axis_tdata[45:30]);
					check_field("payload_length", e.payload_length, m_axis_tdata[54:46]);
					check_field("read_data", e.read_data, m_axis_tdata[62:55]);
				end
				recv_stall <= draw_wait();
				m_axis_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 4000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic push_req(hrmr_pkg::opcode_t op, logic [7:0] d, logic l, logic [1:0] s,
		logic [7:0] i);
		request_t r;
		r.op = op; r.data = d; r.last = l; r.slot = s; r.index = i;
		pending_requests.push_back(r);
		n_items++;
	endtask

	task automatic push_report(logic [7:0] bytes[$]);
		foreach (bytes[k])
			push_req(hrmr_pkg::OP_BYTE, bytes[k], k == bytes.size() - 1, 2'($urandom()),
				8'($urandom()));
	endtask

	task automatic push_read();
		logic [7:0] ix;
		ix = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 40));
		push_req(hrmr_pkg::OP_READ, 8'($urandom()), 1'($urandom()), 2'($urandom()), ix);
	endtask

	// one message, single or fragmented; optional corruptions
	task automatic gen_message(int plen, bit multi, bit bad_ck, bit trunc);
		logic [7:0] rep[$];
		logic [7:0] pay[$];
		logic [7:0] lingo, sum, ck;
		int len, k, m, pos;
		bit wd;
		lingo = ($urandom_range(0, 2) == 0) ? codes[hrmr_pkg::CFG_WIDE] : 8'($urandom());
		wd = (lingo == codes[hrmr_pkg::CFG_WIDE]);
		len = plen + hrmr_pkg::HEADER_FIXED + wd;
		rep = {8'($urandom()), codes[hrmr_pkg::CFG_SINGLE], 8'($urandom())};
		sum = 0;
		if (len > 255 || $urandom_range(0, 3) == 0) begin
			rep.push_back(hrmr_pkg::EXT_LEN_MARK);
			rep.push_back(len[15:8]);
			rep.push_back(len[7:0]);
			sum = len[15:8] + len[7:0];
		end else begin
			rep.push_back(len[7:0]);
			sum = len[7:0];
		end
		rep.push_back(lingo);
		sum += lingo;
		for (int j = 0; j < 3 + wd; j++) begin
			rep.push_back(8'($urandom()));
			sum += rep[$];
		end
		for (int j = 0; j < plen; j++) begin
			pay.push_back(8'($urandom()));
			sum += pay[$];
		end
		ck = -sum;
		if (bad_ck) ck ^= 8'($urandom_range(1, 255));
		if (!multi && rep.size() + plen + 1 <= hrmr_pkg::REPORT_BYTES) begin
			rep = {rep, pay};
			if (!trunc) rep.push_back(ck);
			push_report(rep);
			return;
		end
		rep[1] = codes[hrmr_pkg::CFG_FIRST];
		k = $urandom_range(0, (plen < hrmr_pkg::REPORT_BYTES - rep.size()) ? plen
			: hrmr_pkg::REPORT_BYTES - rep.size());
		for (pos = 0; pos < k; pos++) rep.push_back(pay[pos]);
		push_report(rep);
		while (plen - pos > 61 || (plen - pos > 0 && $urandom_range(0, 2) == 0)) begin
			if ($urandom_range(0, 3) == 0) push_read();
			m = $urandom_range(1, (plen - pos < 62) ? plen - pos : 62);
			rep = {8'($urandom()), codes[hrmr_pkg::CFG_MIDDLE]};
			for (int j = 0; j < m; j++) rep.push_back(pay[pos++]);
			push_report(rep);
		end
		if ($urandom_range(0, 3) == 0) push_read();
		rep = {8'($urandom()), codes[hrmr_pkg::CFG_LAST]};
		while (pos < plen) rep.push_back(pay[pos++]);
		if (!trunc) rep.push_back(ck);
		push_report(rep);
	endtask

	task automatic gen_noise_report();
		logic [7:0] rep[$];
		int n;
		n = $urandom_range(1, 70);
		for (int j = 0; j < n; j++) rep.push_back(8'($urandom()));
		if (n > 1 && $urandom_range(0, 1)) rep[1] = codes[$urandom_range(0, 3)];
		push_report(rep);
	endtask

	task automatic wait_idle();
		while (pending_requests.size() > 0 || s_axis_tvalid || awaited_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(logic [7:0] v[5]);
		cfg_valid <= 1'b1;
		for (int i = 0; i < 5; i++) begin
			cfg_index <= 3'(i);
			cfg_data <= v[i];
			do @(posedge clk); while (!cfg_ready);
			codes[i] = v[i];
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int target);
		int stop, pick, plen;
		stop = n_items + target;
		while (n_items < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, hrmr_pkg::PAYLOAD_BYTES)
					: $urandom_range(0, 20);
				gen_message(plen, $urandom_range(0, 2) == 0, $urandom_range(0, 7) == 0,
					$urandom_range(0, 9) == 0);
			end else if (pick < 72) begin
				gen_noise_report();
			end else if (pick < 88) begin
				push_read();
			end else if (pick < 96) begin
				push_req(hrmr_pkg::OP_RELEASE, 8'($urandom()), 1'($urandom()),
					2'($urandom()), 8'($urandom()));
			end else begin
				push_req(hrmr_pkg::OP_NONE, 8'($urandom()), 1'($urandom()),
					2'($urandom()), 8'($urandom()));
			end
		end
	endtask

	initial begin
		logic [7:0] v[5];
		codes = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4};
		for (int s = 0; s < hrmr_pkg::SLOT_COUNT; s++) begin
			sl_state[s] = hrmr_pkg::SS_EMPTY; sl_lingo[s] = 0; sl_cmd[s] = 0;
			sl_trans[s] = 0; sl_rem[s] = 0; sl_wpos[s] = 0; sl_sum[s] = 0;
		end
		foreach (store[a]) store[a] = 0;
		rpos = 0;
		clear_report();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short, bad link, no slot, good, reads, bad sum, cut, oversize, fragmented, release, no-op
		push_report({8'h01, 8'h00, 8'h00});
		push_report({8'h01, 8'h77, 8'h00, 8'h05, 8'h10});
		push_report({8'h01, 8'h03, 8'hAA, 8'hBB, 8'hCC});
		gen_message(2, 0, 0, 0);
		push_req(hrmr_pkg::OP_READ, 8'h00, 1'b0, 2'd0, 8'd0);
		push_req(hrmr_pkg::OP_READ, 8'hFF, 1'b1, 2'd0, 8'd255);
		push_req(hrmr_pkg::OP_READ, 8'h00, 1'b0, 2'd3, 8'd1);
		gen_message(1, 0, 1, 0);
		gen_message(3, 0, 0, 1);
		push_report({8'h01, 8'h02, 8'h00, 8'h00, 8'h01, 8'h05, 8'h09, 8'h01, 8'h02, 8'h03});
		gen_message(70, 1, 0, 0);
		push_req(hrmr_pkg::OP_RELEASE, 8'h00, 1'b0, 2'd0, 8'd0);
		push_req(hrmr_pkg::OP_NONE, 8'hFF, 1'b1, 2'd3, 8'd255);
		wait_idle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: v = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4};
				1: v = '{8'd255, 8'd0, 8'd254, 8'd128, 8'd255};
				2: v = '{8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
					8'd0};
				3: v = '{8'h10, 8'h10, 8'h20, 8'h20, 8'h80};
				default: v = '{8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h7F};
			endcase
			write_regs(v);
			random_phase(120);
			// hold the sender until the block has drained
			while (pending_requests.size() > 0) @(posedge clk);
			hold_sender = 1'b1;
			while (s_axis_tvalid || awaited_results.size() > 0) @(posedge clk);
			hold_sender = 1'b0;
			random_phase(120);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
